### hdl/vdu_pkg.sv
// ----------------------------------------------------------------------------
// VDU command stream parser package
// Command codes, display action codes and the parameter length table.
// ----------------------------------------------------------------------------
`default_nettype none

package vdu_pkg;

  localparam int unsigned PARAM_DEPTH = 9;

  typedef enum logic [4:0] {
    ACT_CURSOR       = 5'd0,
    ACT_CLS          = 5'd1,
    ACT_HOME         = 5'd2,
    ACT_TEXT_COLOR   = 5'd3,
    ACT_GCOL         = 5'd4,
    ACT_DEF_TEXT     = 5'd5,
    ACT_DEF_GFX      = 5'd6,
    ACT_MODE         = 5'd7,
    ACT_UDG          = 5'd8,
    ACT_GFX_WINDOW   = 5'd9,
    ACT_PLOT         = 5'd10,
    ACT_RST_TEXT_WIN = 5'd11,
    ACT_RST_GFX_WIN  = 5'd12,
    ACT_ORIGIN       = 5'd13,
    ACT_TEXT_CURSOR  = 5'd14,
    ACT_RST_GFX_CUR  = 5'd15,
    ACT_TEXT_WINDOW  = 5'd16,
    ACT_CHAR         = 5'd17
  } action_t;

  localparam logic [7:0] CMD_PRINT_NEXT      = 8'd1;
  localparam logic [7:0] CMD_TEXT_AT_TEXT    = 8'd4;
  localparam logic [7:0] CMD_TEXT_AT_GFX     = 8'd5;
  localparam logic [7:0] CMD_VDU_ENABLE      = 8'd6;
  localparam logic [7:0] CMD_BACKSPACE       = 8'd8;
  localparam logic [7:0] CMD_FORWARD         = 8'd9;
  localparam logic [7:0] CMD_LINE_FEED       = 8'd10;
  localparam logic [7:0] CMD_LINE_UP         = 8'd11;
  localparam logic [7:0] CMD_CLS             = 8'd12;
  localparam logic [7:0] CMD_CR              = 8'd13;
  localparam logic [7:0] CMD_TEXT_COLOR      = 8'd17;
  localparam logic [7:0] CMD_GCOL            = 8'd18;
  localparam logic [7:0] CMD_DEFAULT_COLORS  = 8'd20;
  localparam logic [7:0] CMD_VDU_DISABLE     = 8'd21;
  localparam logic [7:0] CMD_MODE            = 8'd22;
  localparam logic [7:0] CMD_DEFINE_CHAR     = 8'd23;
  localparam logic [7:0] CMD_GFX_WINDOW      = 8'd24;
  localparam logic [7:0] CMD_PLOT            = 8'd25;
  localparam logic [7:0] CMD_RESET_WINDOWS   = 8'd26;
  localparam logic [7:0] CMD_TEXT_WINDOW     = 8'd28;
  localparam logic [7:0] CMD_ORIGIN          = 8'd29;
  localparam logic [7:0] CMD_HOME            = 8'd30;
  localparam logic [7:0] CMD_TAB             = 8'd31;
  localparam logic [7:0] CMD_DELETE          = 8'd127;
  localparam logic [7:0] CHAR_FIRST          = 8'd32;
  localparam logic [15:0] CHAR_SPACE         = 16'd32;

  function automatic logic [3:0] param_len(input logic [4:0] code);
    logic [3:0] len;
    case (code)
      5'd1, 5'd17, 5'd22: len = 4'd1;
      5'd18, 5'd31:       len = 4'd2;
      5'd28, 5'd29:       len = 4'd4;
      5'd19, 5'd25:       len = 4'd5;
      5'd24:              len = 4'd8;
      5'd23:              len = 4'd9;
      default:            len = 4'd0;
    endcase
    return len;
  endfunction

  // True for commands that always expand into at least one action.
  function automatic logic has_action(input logic [7:0] cmd);
    logic r;
    case (cmd)
      CMD_BACKSPACE, CMD_FORWARD, CMD_LINE_FEED, CMD_LINE_UP, CMD_CLS, CMD_CR,
      CMD_TEXT_COLOR, CMD_GCOL, CMD_DEFAULT_COLORS, CMD_DEFINE_CHAR,
      CMD_GFX_WINDOW, CMD_PLOT, CMD_RESET_WINDOWS, CMD_TEXT_WINDOW,
      CMD_ORIGIN, CMD_HOME, CMD_TAB, CMD_DELETE: r = 1'b1;
      default: r = (cmd >= CHAR_FIRST);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/vdu_command_stream_parser.sv
// ----------------------------------------------------------------------------
// VDU command stream parser
// Parses a byte stream of VDU codes and parameters into display actions.
//
// Bytes enter on code_byte with in_valid/in_ready; each action leaves on the
// output ports with out_valid/out_ready, one transaction per action, and
// last_action marks the final action caused by one byte. cfg_wr_en writes
// cfg_wr_data into the display-active bit; while it is 0 every byte is
// accepted and dropped.
// A taken byte sets the job register, and the action sequencer then loads
// its first action into the output register. The sequencer emits one action
// per cycle while the receiver takes them, so a byte with N actions holds the
// block until all N are loaded (up to 11 for a mode change); the next byte is
// taken in the cycle that the last action is loaded. Bytes with one or no
// action flow at one per cycle while the receiver keeps up.
// When the receiver stalls, the output register holds its transaction and the
// sequencer waits, and in_ready falls once the sequencer cannot advance.
// Reset clears the parser state, enables output and sets display active.
// ----------------------------------------------------------------------------
`default_nettype none

module vdu_command_stream_parser #(
  parameter int unsigned MODE_COUNT = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wr_en,
  input  wire logic               cfg_wr_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         code_byte,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [4:0]              action,
  output logic signed [15:0]      arg_a,
  output logic signed [15:0]      arg_b,
  output logic signed [15:0]      arg_c,
  output logic signed [15:0]      arg_d,
  output logic [63:0]             glyph_rows,
  output logic                    text_via_graphics,
  output logic                    last_action
);

  logic       display_active;
  logic [7:0] param_bytes [vdu_pkg::PARAM_DEPTH];
  logic [3:0] bytes_remaining;
  logic [3:0] param_index;
  logic [7:0] pending_command;
  logic       graphics_text_flag;
  logic       output_enabled;

  logic       job_valid;
  logic [7:0] job_cmd;
  logic [3:0] job_step;

  vdu_pkg::action_t   act_q;
  logic signed [15:0] a_q, b_q, c_q, d_q;
  logic [63:0]        glyph_q;
  logic               tvg_q;
  logic               last_q;

  vdu_pkg::action_t   cur_act;
  logic signed [15:0] cur_a, cur_b, cur_c, cur_d;
  logic [63:0]        cur_glyph;
  logic               cur_last;

  logic       in_fire;
  logic       parse;
  logic       out_load;
  logic       job_done;
  logic [7:0] cmd_next;
  logic [3:0] rem_next;
  logic       complete;
  logic       run;
  logic       mode_ok;
  logic       start_job;
  logic       gtf_next;
  logic       oe_next;

  logic signed [15:0] s01, s12, s23, s34, s45, s67;

  assign out_load = job_valid && (!out_valid || out_ready);
  assign job_done = out_load && cur_last;
  assign in_ready = !job_valid || job_done;
  assign in_fire  = in_valid && in_ready;
  assign parse    = in_fire && display_active;

  always_comb begin
    if (bytes_remaining == 4'd0) begin
      cmd_next = code_byte;
      rem_next = (code_byte < vdu_pkg::CHAR_FIRST) ? vdu_pkg::param_len(code_byte[4:0])
                                                   : 4'd0;
    end else begin
      cmd_next = pending_command;
      rem_next = bytes_remaining - 4'd1;
    end
    complete = (rem_next == 4'd0);
    run = complete && (output_enabled || cmd_next == vdu_pkg::CMD_PRINT_NEXT ||
                       cmd_next == vdu_pkg::CMD_VDU_ENABLE);
    mode_ok = ({1'b0, code_byte} < 9'(MODE_COUNT));
    gtf_next = graphics_text_flag;
    oe_next = output_enabled;
    start_job = 1'b0;
    if (run) begin
      case (cmd_next)
        vdu_pkg::CMD_TEXT_AT_TEXT: gtf_next = 1'b0;
        vdu_pkg::CMD_TEXT_AT_GFX:  gtf_next = 1'b1;
        vdu_pkg::CMD_VDU_ENABLE:   oe_next = 1'b1;
        vdu_pkg::CMD_VDU_DISABLE:  oe_next = 1'b0;
        vdu_pkg::CMD_MODE: begin
          if (mode_ok) begin
            gtf_next = 1'b0;
            oe_next = 1'b1;
            start_job = 1'b1;
          end
        end
        default: start_job = vdu_pkg::has_action(cmd_next);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      display_active <= 1'b1;
      bytes_remaining <= 4'd0;
      param_index <= 4'd0;
      pending_command <= 8'd0;
      graphics_text_flag <= 1'b0;
      output_enabled <= 1'b1;
    end else begin
      if (cfg_wr_en) begin
        display_active <= cfg_wr_data;
      end
      if (parse) begin
        pending_command <= cmd_next;
        bytes_remaining <= rem_next;
        graphics_text_flag <= gtf_next;
        output_enabled <= oe_next;
        if (bytes_remaining == 4'd0) begin
          param_index <= 4'd0;
        end else if (param_index < 4'(vdu_pkg::PARAM_DEPTH)) begin
          param_index <= param_index + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (parse && bytes_remaining != 4'd0 && param_index < 4'(vdu_pkg::PARAM_DEPTH)) begin
      param_bytes[param_index] <= code_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      job_cmd <= 8'd0;
      job_step <= 4'd0;
    end else if (parse && start_job) begin
      job_valid <= 1'b1;
      job_cmd <= cmd_next;
      job_step <= 4'd0;
    end else if (job_done) begin
      job_valid <= 1'b0;
    end else if (out_load) begin
      job_step <= job_step + 4'd1;
    end
  end

  assign s01 = {param_bytes[1], param_bytes[0]};
  assign s12 = {param_bytes[2], param_bytes[1]};
  assign s23 = {param_bytes[3], param_bytes[2]};
  assign s34 = {param_bytes[4], param_bytes[3]};
  assign s45 = {param_bytes[5], param_bytes[4]};
  assign s67 = {param_bytes[7], param_bytes[6]};

  always_comb begin
    cur_act = vdu_pkg::ACT_CHAR;
    cur_a = 16'sd0;
    cur_b = 16'sd0;
    cur_c = 16'sd0;
    cur_d = 16'sd0;
    cur_glyph = 64'd0;
    cur_last = 1'b1;
    case (job_cmd)
      vdu_pkg::CMD_BACKSPACE, vdu_pkg::CMD_FORWARD, vdu_pkg::CMD_LINE_FEED,
      vdu_pkg::CMD_LINE_UP, vdu_pkg::CMD_CR: begin
        cur_act = vdu_pkg::ACT_CURSOR;
        cur_a = {8'd0, job_cmd};
      end
      vdu_pkg::CMD_CLS: begin
        cur_act = (job_step == 4'd0) ? vdu_pkg::ACT_CLS : vdu_pkg::ACT_HOME;
        cur_last = (job_step != 4'd0);
      end
      vdu_pkg::CMD_TEXT_COLOR: begin
        cur_act = vdu_pkg::ACT_TEXT_COLOR;
        cur_a = {8'd0, param_bytes[0]};
      end
      vdu_pkg::CMD_GCOL: begin
        cur_act = vdu_pkg::ACT_GCOL;
        cur_a = {8'd0, param_bytes[0]};
        cur_b = {8'd0, param_bytes[1]};
      end
      vdu_pkg::CMD_DEFAULT_COLORS: begin
        cur_act = (job_step == 4'd0) ? vdu_pkg::ACT_DEF_TEXT : vdu_pkg::ACT_DEF_GFX;
        cur_last = (job_step != 4'd0);
      end
      vdu_pkg::CMD_MODE: begin
        cur_last = 1'b0;
        case (job_step)
          4'd0: begin
            cur_act = vdu_pkg::ACT_MODE;
            cur_a = {8'd0, param_bytes[0]};
          end
          4'd1: cur_act = vdu_pkg::ACT_DEF_TEXT;
          4'd2: cur_act = vdu_pkg::ACT_DEF_GFX;
          4'd3: cur_act = vdu_pkg::ACT_RST_TEXT_WIN;
          4'd4: cur_act = vdu_pkg::ACT_RST_GFX_WIN;
          4'd5: cur_act = vdu_pkg::ACT_ORIGIN;
          4'd6: cur_act = vdu_pkg::ACT_TEXT_CURSOR;
          4'd7: cur_act = vdu_pkg::ACT_RST_GFX_CUR;
          4'd8: cur_act = vdu_pkg::ACT_CLS;
          4'd9: cur_act = vdu_pkg::ACT_HOME;
          default: begin
            cur_act = vdu_pkg::ACT_HOME;
            cur_last = 1'b1;
          end
        endcase
      end
      vdu_pkg::CMD_DEFINE_CHAR: begin
        cur_act = vdu_pkg::ACT_UDG;
        cur_a = {8'd0, param_bytes[0]};
        cur_glyph = {param_bytes[8], param_bytes[7], param_bytes[6], param_bytes[5],
                     param_bytes[4], param_bytes[3], param_bytes[2], param_bytes[1]};
      end
      vdu_pkg::CMD_GFX_WINDOW: begin
        cur_act = vdu_pkg::ACT_GFX_WINDOW;
        cur_a = (s01 < s45) ? s01 : s45;
        cur_c = (s01 < s45) ? s45 : s01;
        cur_b = (s23 < s67) ? s23 : s67;
        cur_d = (s23 < s67) ? s67 : s23;
      end
      vdu_pkg::CMD_PLOT: begin
        cur_act = vdu_pkg::ACT_PLOT;
        cur_a = {8'd0, param_bytes[0]};
        cur_b = s12;
        cur_c = s34;
      end
      vdu_pkg::CMD_RESET_WINDOWS: begin
        cur_last = 1'b0;
        case (job_step)
          4'd0: cur_act = vdu_pkg::ACT_RST_TEXT_WIN;
          4'd1: cur_act = vdu_pkg::ACT_RST_GFX_WIN;
          4'd2: cur_act = vdu_pkg::ACT_ORIGIN;
          4'd3: cur_act = vdu_pkg::ACT_TEXT_CURSOR;
          default: begin
            cur_act = vdu_pkg::ACT_RST_GFX_CUR;
            cur_last = 1'b1;
          end
        endcase
      end
      vdu_pkg::CMD_TEXT_WINDOW: begin
        if (job_step == 4'd0) begin
          cur_act = vdu_pkg::ACT_TEXT_WINDOW;
          cur_last = 1'b0;
          if (param_bytes[0] < param_bytes[2]) begin
            cur_a = {8'd0, param_bytes[0]};
            cur_c = {8'd0, param_bytes[2]};
          end else begin
            cur_a = {8'd0, param_bytes[2]};
            cur_c = {8'd0, param_bytes[0]};
          end
          if (param_bytes[1] > param_bytes[3]) begin
            cur_b = {8'd0, param_bytes[1]};
            cur_d = {8'd0, param_bytes[3]};
          end else begin
            cur_b = {8'd0, param_bytes[3]};
            cur_d = {8'd0, param_bytes[1]};
          end
        end else begin
          cur_act = vdu_pkg::ACT_HOME;
        end
      end
      vdu_pkg::CMD_ORIGIN: begin
        cur_act = vdu_pkg::ACT_ORIGIN;
        cur_a = s01;
        cur_b = s23;
      end
      vdu_pkg::CMD_HOME: cur_act = vdu_pkg::ACT_HOME;
      vdu_pkg::CMD_TAB: begin
        cur_act = vdu_pkg::ACT_TEXT_CURSOR;
        cur_a = {8'd0, param_bytes[0]};
        cur_b = {8'd0, param_bytes[1]};
      end
      vdu_pkg::CMD_DELETE: begin
        if (job_step == 4'd1) begin
          cur_act = vdu_pkg::ACT_CHAR;
          cur_a = vdu_pkg::CHAR_SPACE;
          cur_last = 1'b0;
        end else begin
          cur_act = vdu_pkg::ACT_CURSOR;
          cur_a = {8'd0, vdu_pkg::CMD_FORWARD};
          cur_last = (job_step != 4'd0);
        end
      end
      default: begin
        cur_act = vdu_pkg::ACT_CHAR;
        cur_a = {8'd0, job_cmd};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      act_q <= cur_act;
      a_q <= cur_a;
      b_q <= cur_b;
      c_q <= cur_c;
      d_q <= cur_d;
      glyph_q <= cur_glyph;
      tvg_q <= graphics_text_flag;
      last_q <= cur_last;
    end
  end

  assign action = act_q;
  assign arg_a = a_q;
  assign arg_b = b_q;
  assign arg_c = c_q;
  assign arg_d = d_q;
  assign glyph_rows = glyph_q;
  assign text_via_graphics = tvg_q;
  assign last_action = last_q;

endmodule

`default_nettype wire

### test/vdu_command_stream_parser_checker.sv
// ----------------------------------------------------------------------------
// VDU command stream parser checker
// Watches the configuration write, the byte channel and the action channel.
// Each accepted byte is run through a local model of the parser, and the
// display actions it causes are queued. Each accepted action transaction is
// compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module vdu_command_stream_parser_checker #(
  parameter int unsigned MODE_COUNT = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [7:0]         code_byte,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [4:0]         action,
  input  logic signed [15:0] arg_a,
  input  logic signed [15:0] arg_b,
  input  logic signed [15:0] arg_c,
  input  logic signed [15:0] arg_d,
  input  logic [63:0]        glyph_rows,
  input  logic               text_via_graphics,
  input  logic               last_action,
  output int                 mismatches,
  output int                 outstanding,
  output int                 bytes_seen,
  output int                 actions_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    vdu_pkg::action_t   act;
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [15:0] c;
    logic signed [15:0] d;
    logic [63:0]        glyph;
    logic               tvg;
    logic               last;
  } vdu_action_t;

  localparam logic [3:0] ARG_COUNT [32] = '{
    4'd0, 4'd1, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
    4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
    4'd0, 4'd1, 4'd2, 4'd5, 4'd0, 4'd0, 4'd1, 4'd9,
    4'd8, 4'd5, 4'd0, 4'd0, 4'd4, 4'd4, 4'd0, 4'd2
  };

  vdu_action_t due_actions[$];
  vdu_action_t byte_actions[$];
  logic        display_on;
  logic [7:0]  arg_bytes [9];
  logic [3:0]  args_left;
  logic [3:0]  arg_fill;
  logic [7:0]  open_cmd;
  logic        gfx_text;
  logic        vdu_on;

  function automatic void emit(input vdu_pkg::action_t act,
                               input logic signed [15:0] a = 16'sd0,
                               input logic signed [15:0] b = 16'sd0,
                               input logic signed [15:0] c = 16'sd0,
                               input logic signed [15:0] d = 16'sd0,
                               input logic [63:0] glyph = 64'd0);
    vdu_action_t r;
    r.act = act;
    r.a = a;
    r.b = b;
    r.c = c;
    r.d = d;
    r.glyph = glyph;
    r.tvg = 1'b0;
    r.last = 1'b0;
    byte_actions.push_back(r);
  endfunction

  function automatic logic signed [15:0] widen(input logic [7:0] v);
    return {8'd0, v};
  endfunction

  function automatic logic signed [15:0] word_at(input int at);
    return {arg_bytes[at + 1], arg_bytes[at]};
  endfunction

  function automatic logic signed [15:0] lesser(input logic signed [15:0] p,
                                                input logic signed [15:0] q);
    return (p < q) ? p : q;
  endfunction

  function automatic logic signed [15:0] greater(input logic signed [15:0] p,
                                                 input logic signed [15:0] q);
    return (p > q) ? p : q;
  endfunction

  function automatic void expand(input logic [7:0] cmd);
    logic signed [15:0] x1, y1, x2, y2;
    logic [63:0] rows;
    case (cmd)
      vdu_pkg::CMD_TEXT_AT_TEXT: gfx_text = 1'b0;
      vdu_pkg::CMD_TEXT_AT_GFX: gfx_text = 1'b1;
      vdu_pkg::CMD_VDU_ENABLE: vdu_on = 1'b1;
      vdu_pkg::CMD_VDU_DISABLE: vdu_on = 1'b0;
      vdu_pkg::CMD_BACKSPACE, vdu_pkg::CMD_FORWARD, vdu_pkg::CMD_LINE_FEED,
      vdu_pkg::CMD_LINE_UP, vdu_pkg::CMD_CR: begin
        emit(vdu_pkg::ACT_CURSOR, widen(cmd));
      end
      vdu_pkg::CMD_CLS: begin
        emit(vdu_pkg::ACT_CLS);
        emit(vdu_pkg::ACT_HOME);
      end
      vdu_pkg::CMD_TEXT_COLOR: emit(vdu_pkg::ACT_TEXT_COLOR, widen(arg_bytes[0]));
      vdu_pkg::CMD_GCOL: emit(vdu_pkg::ACT_GCOL, widen(arg_bytes[0]), widen(arg_bytes[1]));
      vdu_pkg::CMD_DEFAULT_COLORS: begin
        emit(vdu_pkg::ACT_DEF_TEXT);
        emit(vdu_pkg::ACT_DEF_GFX);
      end
      vdu_pkg::CMD_MODE: begin
        if (arg_bytes[0] < MODE_COUNT) begin
          emit(vdu_pkg::ACT_MODE, widen(arg_bytes[0]));
          emit(vdu_pkg::ACT_DEF_TEXT);
          emit(vdu_pkg::ACT_DEF_GFX);
          emit(vdu_pkg::ACT_RST_TEXT_WIN);
          emit(vdu_pkg::ACT_RST_GFX_WIN);
          emit(vdu_pkg::ACT_ORIGIN);
          emit(vdu_pkg::ACT_TEXT_CURSOR);
          emit(vdu_pkg::ACT_RST_GFX_CUR);
          emit(vdu_pkg::ACT_CLS);
          emit(vdu_pkg::ACT_HOME);
          emit(vdu_pkg::ACT_HOME);
          vdu_on = 1'b1;
          gfx_text = 1'b0;
        end
      end
      vdu_pkg::CMD_DEFINE_CHAR: begin
        rows = {arg_bytes[8], arg_bytes[7], arg_bytes[6], arg_bytes[5],
                arg_bytes[4], arg_bytes[3], arg_bytes[2], arg_bytes[1]};
        emit(vdu_pkg::ACT_UDG, widen(arg_bytes[0]), 16'sd0, 16'sd0, 16'sd0, rows);
      end
      vdu_pkg::CMD_GFX_WINDOW: begin
        x1 = word_at(0);
        y1 = word_at(2);
        x2 = word_at(4);
        y2 = word_at(6);
        emit(vdu_pkg::ACT_GFX_WINDOW, lesser(x1, x2), lesser(y1, y2), greater(x1, x2),
             greater(y1, y2));
      end
      vdu_pkg::CMD_PLOT: emit(vdu_pkg::ACT_PLOT, widen(arg_bytes[0]), word_at(1), word_at(3));
      vdu_pkg::CMD_RESET_WINDOWS: begin
        emit(vdu_pkg::ACT_RST_TEXT_WIN);
        emit(vdu_pkg::ACT_RST_GFX_WIN);
        emit(vdu_pkg::ACT_ORIGIN);
        emit(vdu_pkg::ACT_TEXT_CURSOR);
        emit(vdu_pkg::ACT_RST_GFX_CUR);
      end
      vdu_pkg::CMD_TEXT_WINDOW: begin
        emit(vdu_pkg::ACT_TEXT_WINDOW,
             lesser(widen(arg_bytes[0]), widen(arg_bytes[2])),
             greater(widen(arg_bytes[1]), widen(arg_bytes[3])),
             greater(widen(arg_bytes[0]), widen(arg_bytes[2])),
             lesser(widen(arg_bytes[1]), widen(arg_bytes[3])));
        emit(vdu_pkg::ACT_HOME);
      end
      vdu_pkg::CMD_ORIGIN: emit(vdu_pkg::ACT_ORIGIN, word_at(0), word_at(2));
      vdu_pkg::CMD_HOME: emit(vdu_pkg::ACT_HOME);
      vdu_pkg::CMD_TAB: begin
        emit(vdu_pkg::ACT_TEXT_CURSOR, widen(arg_bytes[0]), widen(arg_bytes[1]));
      end
      vdu_pkg::CMD_DELETE: begin
        emit(vdu_pkg::ACT_CURSOR, widen(vdu_pkg::CMD_FORWARD));
        emit(vdu_pkg::ACT_CHAR, vdu_pkg::CHAR_SPACE);
        emit(vdu_pkg::ACT_CURSOR, widen(vdu_pkg::CMD_FORWARD));
      end
      default: begin
        if (cmd >= vdu_pkg::CHAR_FIRST) emit(vdu_pkg::ACT_CHAR, widen(cmd));
      end
    endcase
  endfunction

  function automatic void take_byte(input logic [7:0] b);
    if (!display_on) return;
    if (args_left == 4'd0) begin
      open_cmd = b;
      args_left = (b < vdu_pkg::CHAR_FIRST) ? ARG_COUNT[b[4:0]] : 4'd0;
      arg_fill = 4'd0;
    end else begin
      if (arg_fill < 4'd9) begin
        arg_bytes[arg_fill] = b;
        arg_fill++;
      end
      args_left--;
    end
    if (args_left != 4'd0) return;
    if (!vdu_on && open_cmd != vdu_pkg::CMD_PRINT_NEXT &&
        open_cmd != vdu_pkg::CMD_VDU_ENABLE) return;
    byte_actions.delete();
    expand(open_cmd);
    foreach (byte_actions[k]) begin
      byte_actions[k].tvg = gfx_text;
      byte_actions[k].last = (k == byte_actions.size() - 1);
      due_actions.push_back(byte_actions[k]);
    end
  endfunction

  function automatic void check_action();
    vdu_action_t e;
    if (due_actions.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Unexpected action %0d at %0t with nothing pending.", action, $time);
      return;
    end
    e = due_actions.pop_front();
    if (action !== e.act || arg_a !== e.a || arg_b !== e.b || arg_c !== e.c ||
        arg_d !== e.d || glyph_rows !== e.glyph || text_via_graphics !== e.tvg ||
        last_action !== e.last) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("Mismatch at %0t, expected: action %0d a %0d b %0d c %0d d %0d",
                 $time, e.act, e.a, e.b, e.c, e.d);
        $display("  glyph %h tvg %0b last %0b", e.glyph, e.tvg, e.last);
        $display("  actual: action %0d a %0d b %0d c %0d d %0d",
                 action, arg_a, arg_b, arg_c, arg_d);
        $display("  glyph %h tvg %0b last %0b", glyph_rows, text_via_graphics,
                 last_action);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      due_actions.delete();
      display_on = 1'b1;
      foreach (arg_bytes[i]) arg_bytes[i] = 8'd0;
      args_left = 4'd0;
      arg_fill = 4'd0;
      open_cmd = 8'd0;
      gfx_text = 1'b0;
      vdu_on = 1'b1;
      mismatches = 0;
      bytes_seen = 0;
      actions_seen = 0;
    end else begin
      if (cfg_wr_en) display_on = cfg_wr_data;
      if (in_valid && in_ready) begin
        take_byte(code_byte);
        bytes_seen++;
      end
      if (out_valid && out_ready) begin
        check_action();
        actions_seen++;
      end
    end
    outstanding = due_actions.size();
  end

endmodule

### test/vdu_command_stream_parser_test.sv
// ----------------------------------------------------------------------------
// VDU command stream parser testbench
// Drives a byte stream into the parser: a directed opening over the special
// codes, then mostly well-formed random commands with some truncated ones and
// noise, a long output stall, a display-off phase and a final stretch with no
// idling. A separate checker predicts and compares every display action.
// ----------------------------------------------------------------------------
module vdu_command_stream_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MODE_COUNT = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 200;
  localparam logic [7:0] OPENING [34] = '{
    8'd32, 8'd255, vdu_pkg::CMD_DELETE, vdu_pkg::CMD_BACKSPACE, vdu_pkg::CMD_CR,
    vdu_pkg::CMD_CLS, 8'd0, 8'd7,
    vdu_pkg::CMD_TEXT_AT_GFX, 8'd65, vdu_pkg::CMD_MODE, 8'd8, vdu_pkg::CMD_MODE, 8'd7,
    vdu_pkg::CMD_VDU_DISABLE, 8'd66, vdu_pkg::CMD_PRINT_NEXT, 8'd0,
    vdu_pkg::CMD_VDU_ENABLE,
    vdu_pkg::CMD_GFX_WINDOW, 8'hFF, 8'h7F, 8'h00, 8'h80, 8'h00, 8'h80, 8'hFF, 8'h7F,
    vdu_pkg::CMD_TEXT_WINDOW, 8'hFF, 8'h00, 8'h00, 8'hFF, vdu_pkg::CMD_TEXT_AT_TEXT
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic               cfg_wr_data = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         code_byte = 8'd0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [4:0]         action;
  logic signed [15:0] arg_a;
  logic signed [15:0] arg_b;
  logic signed [15:0] arg_c;
  logic signed [15:0] arg_d;
  logic [63:0]        glyph_rows;
  logic               text_via_graphics;
  logic               last_action;

  int mismatches;
  int outstanding;
  int bytes_seen;
  int actions_seen;
  int cycles = 0;
  int bytes_sent = 0;
  int target;
  bit idle_in = 1'b1;
  bit idle_out = 1'b1;
  bit hold_req = 1'b0;

  always #1 clk = ~clk;

  vdu_command_stream_parser #(.MODE_COUNT(MODE_COUNT)) dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .code_byte(code_byte),
    .out_valid(out_valid), .out_ready(out_ready), .action(action),
    .arg_a(arg_a), .arg_b(arg_b), .arg_c(arg_c), .arg_d(arg_d),
    .glyph_rows(glyph_rows), .text_via_graphics(text_via_graphics),
    .last_action(last_action)
  );

  vdu_command_stream_parser_checker #(.MODE_COUNT(MODE_COUNT)) action_check (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .code_byte(code_byte),
    .out_valid(out_valid), .out_ready(out_ready), .action(action),
    .arg_a(arg_a), .arg_b(arg_b), .arg_c(arg_c), .arg_d(arg_d),
    .glyph_rows(glyph_rows), .text_via_graphics(text_via_graphics),
    .last_action(last_action), .mismatches(mismatches),
    .outstanding(outstanding), .bytes_seen(bytes_seen),
    .actions_seen(actions_seen)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles.", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (idle_out && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(0, 12)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (idle_in && $urandom_range(0, 5) == 0)
      repeat ($urandom_range(1, 13)) @(negedge clk);
    in_valid = 1'b1;
    code_byte = b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
    bytes_sent++;
  endtask

  function automatic logic [7:0] param_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h7F;
      3: return 8'h80;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_random_command();
    int pick;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      send_byte(8'($urandom_range(32, 255)));
    end else if (pick < 36) begin
      send_byte(vdu_pkg::CMD_DELETE);
    end else if (pick < 88) begin
      c = 8'($urandom_range(0, 31));
      send_byte(c);
      if (c == vdu_pkg::CMD_MODE)
        send_byte(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, MODE_COUNT - 1)));
      else
        repeat (vdu_pkg::param_len(c[4:0])) send_byte(param_byte());
      if (c == vdu_pkg::CMD_VDU_DISABLE) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(32, 126)));
        send_byte(vdu_pkg::CMD_VDU_ENABLE);
      end
    end else if (pick < 94) begin
      c = 8'($urandom_range(0, 31));
      if (c == vdu_pkg::CMD_VDU_DISABLE) c = vdu_pkg::CMD_VDU_ENABLE;
      send_byte(c);
      repeat ($urandom_range(0, vdu_pkg::param_len(c[4:0]))) send_byte(param_byte());
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic drain();
    while (outstanding != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic set_display(input logic on);
    drain();
    cfg_wr_en = 1'b1;
    cfg_wr_data = on;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    set_display(1'b1);

    foreach (OPENING[i]) send_byte(OPENING[i]);

    while (bytes_sent < 90) send_random_command();
    while (outstanding != 0) @(negedge clk);

    hold_req = 1'b1;
    target = bytes_sent + 30;
    while (bytes_sent < target) send_random_command();

    set_display(1'b0);
    target = bytes_sent + 12;
    while (bytes_sent < target) send_byte(8'($urandom_range(0, 255)));
    set_display(1'b1);

    target = bytes_sent + 40;
    while (bytes_sent < target) send_random_command();

    idle_in = 1'b0;
    idle_out = 1'b0;
    target = bytes_sent + 40;
    while (bytes_sent < target) send_random_command();

    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Sent %0d bytes and checked %0d display actions.", bytes_seen, actions_seen);
    $display("Covered special codes, random commands, a long output stall and display off.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/vdu_pkg.sv
hdl/vdu_command_stream_parser.sv
test/vdu_command_stream_parser_checker.sv
test/vdu_command_stream_parser_test.sv
